// ----- hdl/qvr_pkg.sv -----
// Shared types and constants for the quaternion vector rotation block.
package qvr_pkg;

  localparam int unsigned QW   = 16;          // quaternion and vector field width
  localparam int unsigned FRAC = 28;          // fraction bits of a matrix element
  localparam int unsigned PQW  = 2 * QW;      // quaternion product width
  localparam int unsigned MW   = PQW + 2;     // matrix element width
  localparam int unsigned PW   = MW + QW;     // element times vector component
  localparam int unsigned SW   = PW + 2;      // sum of three lane products
  localparam int unsigned RW   = SW - FRAC;   // rounded sum width
  localparam int unsigned NDIM = 3;

  localparam logic signed [MW-1:0] ONE_Q28  = MW'(64'sd1 <<< FRAC);
  localparam logic signed [SW-1:0] HALF_Q28 = SW'(64'sd1 <<< (FRAC - 1));
  localparam logic signed [RW-1:0] OUT_MAX  = RW'(32767);
  localparam logic signed [RW-1:0] OUT_MIN  = -RW'(32768);

  // Operation codes.
  localparam logic OP_BODY_TO_EARTH = 1'b0;
  localparam logic OP_EARTH_TO_BODY = 1'b1;

  typedef logic signed [QW-1:0]  comp_t;
  typedef logic signed [PQW-1:0] qprod_t;
  typedef logic signed [MW-1:0]  elem_t;
  typedef logic signed [PW-1:0]  lprod_t;

  typedef elem_t [NDIM-1:0] row_t;
  typedef comp_t [NDIM-1:0] vec_t;

  typedef struct packed {
    logic  operation;
    comp_t quat_w;
    comp_t quat_x;
    comp_t quat_y;
    comp_t quat_z;
    comp_t vec_in_x;
    comp_t vec_in_y;
    comp_t vec_in_z;
  } in_word_t;

  typedef struct packed {
    comp_t vec_out_x;
    comp_t vec_out_y;
    comp_t vec_out_z;
    logic  saturated;
  } out_word_t;

endpackage

// ----- hdl/quaternion_vector_rotation.sv -----
// Top level of the quaternion vector rotation block: matrix builder, three lanes, merge.
//
// The block takes one word per clock while not stalled and rotates its 3-vector by the
// quaternion it carries: operation 0 applies the rotation matrix (body to earth),
// operation 1 its transpose (earth to body). The quaternion is used as given, without
// normalization, so a quaternion that is not of unit length also scales the vector. Each
// component is rounded half up and saturated to 16 bits; the saturated flag reports
// whether any component was clipped. Throughput is one word per clock cycle while the
// output does not stall. From acceptance to the result word, one stage forms the
// quaternion products, one assembles the matrix rows, one holds the three lane
// multipliers per component, and the last adds, rounds and saturates into the output
// register. The whole pipeline advances together, so a stall on the output holds every
// stage and stalls the input in the same cycle.
module quaternion_vector_rotation (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  qvr_pkg::in_word_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output qvr_pkg::out_word_t out_data
);

  logic adv;
  logic v1_r, v2_r, v3_r, out_valid_r;

  // The pipeline moves whenever the output register is empty or being taken.
  assign adv      = !out_valid_r || !out_stall;
  assign in_stall = !adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      v1_r        <= in_valid;
      v2_r        <= v1_r;
      v3_r        <= v2_r;
      out_valid_r <= v3_r;
    end
  end

  qvr_pkg::row_t rows [qvr_pkg::NDIM];
  qvr_pkg::vec_t vec;

  qvr_matrix u_matrix (
    .clk     (clk),
    .adv     (adv),
    .in_data (in_data),
    .rows    (rows),
    .vec     (vec)
  );

  // Each lane computes one output component from its row of the matrix.
  qvr_pkg::comp_t lane_res [qvr_pkg::NDIM];
  logic [qvr_pkg::NDIM-1:0] lane_clip;

  for (genvar g = 0; g < qvr_pkg::NDIM; g++) begin : g_lane
    qvr_lane u_lane (
      .clk     (clk),
      .adv     (adv),
      .row     (rows[g]),
      .vec     (vec),
      .result  (lane_res[g]),
      .clipped (lane_clip[g])
    );
  end

  // Merge: gather the three components and combine their clip flags.
  qvr_pkg::out_word_t out_data_r, out_data_nxt;

  always_comb begin
    out_data_nxt.vec_out_x = lane_res[0];
    out_data_nxt.vec_out_y = lane_res[1];
    out_data_nxt.vec_out_z = lane_res[2];
    out_data_nxt.saturated = |lane_clip;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ----- hdl/qvr_matrix.sv -----
// Rotation matrix builder: quaternion products, then matrix rows per lane.
module qvr_matrix (
  input  logic                       clk,
  input  logic                       adv,
  input  qvr_pkg::in_word_t          in_data,
  output qvr_pkg::row_t              rows [qvr_pkg::NDIM],
  output qvr_pkg::vec_t              vec
);

  // First stage: the nine quaternion products.
  qvr_pkg::qprod_t xx_r, yy_r, zz_r, xy_r, xz_r, yz_r, wx_r, wy_r, wz_r;
  logic            op_r;
  qvr_pkg::vec_t   vec1_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      xx_r   <= in_data.quat_x * in_data.quat_x;
      yy_r   <= in_data.quat_y * in_data.quat_y;
      zz_r   <= in_data.quat_z * in_data.quat_z;
      xy_r   <= in_data.quat_x * in_data.quat_y;
      xz_r   <= in_data.quat_x * in_data.quat_z;
      yz_r   <= in_data.quat_y * in_data.quat_z;
      wx_r   <= in_data.quat_w * in_data.quat_x;
      wy_r   <= in_data.quat_w * in_data.quat_y;
      wz_r   <= in_data.quat_w * in_data.quat_z;
      op_r   <= in_data.operation;
      vec1_r <= {in_data.vec_in_z, in_data.vec_in_y, in_data.vec_in_x};
    end
  end

  // Second stage: matrix elements, rows or columns chosen by the operation.
  qvr_pkg::elem_t m [qvr_pkg::NDIM][qvr_pkg::NDIM];
  qvr_pkg::row_t  rows_nxt [qvr_pkg::NDIM];
  qvr_pkg::row_t  rows_r [qvr_pkg::NDIM];
  qvr_pkg::vec_t  vec2_r;

  always_comb begin
    m[0][0] = qvr_pkg::ONE_Q28 - (qvr_pkg::MW'(yy_r) <<< 1) - (qvr_pkg::MW'(zz_r) <<< 1);
    m[1][1] = qvr_pkg::ONE_Q28 - (qvr_pkg::MW'(xx_r) <<< 1) - (qvr_pkg::MW'(zz_r) <<< 1);
    m[2][2] = qvr_pkg::ONE_Q28 - (qvr_pkg::MW'(xx_r) <<< 1) - (qvr_pkg::MW'(yy_r) <<< 1);
    m[0][1] = (qvr_pkg::MW'(xy_r) - qvr_pkg::MW'(wz_r)) <<< 1;
    m[0][2] = (qvr_pkg::MW'(xz_r) + qvr_pkg::MW'(wy_r)) <<< 1;
    m[1][0] = (qvr_pkg::MW'(xy_r) + qvr_pkg::MW'(wz_r)) <<< 1;
    m[1][2] = (qvr_pkg::MW'(yz_r) - qvr_pkg::MW'(wx_r)) <<< 1;
    m[2][0] = (qvr_pkg::MW'(xz_r) - qvr_pkg::MW'(wy_r)) <<< 1;
    m[2][1] = (qvr_pkg::MW'(yz_r) + qvr_pkg::MW'(wx_r)) <<< 1;
    for (int i = 0; i < qvr_pkg::NDIM; i++) begin
      for (int k = 0; k < qvr_pkg::NDIM; k++) begin
        rows_nxt[i][k] = (op_r == qvr_pkg::OP_EARTH_TO_BODY) ? m[k][i] : m[i][k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rows_r <= rows_nxt;
      vec2_r <= vec1_r;
    end
  end

  assign rows = rows_r;
  assign vec  = vec2_r;

endmodule

// ----- hdl/qvr_lane.sv -----
// One lane: dot product of a matrix row with the vector, rounded and saturated.
module qvr_lane (
  input  logic                clk,
  input  logic                adv,
  input  qvr_pkg::row_t       row,
  input  qvr_pkg::vec_t       vec,
  output qvr_pkg::comp_t      result,
  output logic                clipped
);

  qvr_pkg::lprod_t prod_r [qvr_pkg::NDIM];

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < qvr_pkg::NDIM; k++) begin
        prod_r[k] <= qvr_pkg::PW'($signed(row[k])) * qvr_pkg::PW'($signed(vec[k]));
      end
    end
  end

  logic signed [qvr_pkg::SW-1:0] sum;
  logic signed [qvr_pkg::RW-1:0] rnd;

  // Adding one half and dropping the fraction rounds half up.
  always_comb begin
    sum = qvr_pkg::SW'(prod_r[0]) + qvr_pkg::SW'(prod_r[1]) + qvr_pkg::SW'(prod_r[2])
          + qvr_pkg::HALF_Q28;
    rnd = $signed(sum[qvr_pkg::SW-1:qvr_pkg::FRAC]);
    if (rnd > qvr_pkg::OUT_MAX) begin
      result  = qvr_pkg::QW'(qvr_pkg::OUT_MAX);
      clipped = 1'b1;
    end else if (rnd < qvr_pkg::OUT_MIN) begin
      result  = qvr_pkg::QW'(qvr_pkg::OUT_MIN);
      clipped = 1'b1;
    end else begin
      result  = rnd[qvr_pkg::QW-1:0];
      clipped = 1'b0;
    end
  end

endmodule
